[src/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is low.
`define SWPB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SWPB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/swpb_pkg.sv]
// ----------------------------------------------------------------------------
// swpb_pkg
// Shared types, constants and helpers of the sliding-window packet buffer.
// ----------------------------------------------------------------------------
package swpb_pkg;

  localparam int DEF_STORE_DEPTH = 16;
  localparam int MAX_WIN         = 31;   // largest window a 5-bit size can ask for
  localparam int WS_W            = 5;
  localparam int SEQ_W           = 32;
  localparam int PAY_W           = 64;
  localparam int FUNC_W          = 3;
  localparam int REM_W           = 5;
  localparam int CNT_W           = 6;
  localparam logic [WS_W-1:0] WS_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD    = 3'd0,
    OP_READ   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SLIDE  = 3'd3,
    OP_SET    = 3'd4,
    OP_QUERY  = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] payload;
  } item_t;

  // Slots covered by a circular run of 'count' slots from 'start', modulo 'size'.
  function automatic logic [MAX_WIN-1:0] slot_mask(input logic [REM_W-1:0] start,
                                                   input logic [CNT_W-1:0] count,
                                                   input logic [REM_W-1:0] size);
    logic [MAX_WIN-1:0] m;
    logic [CNT_W-1:0]   jv;
    logic [CNT_W-1:0]   off;
    m = '0;
    for (int j = 0; j < MAX_WIN; j++) begin
      jv = CNT_W'(j);
      if (jv >= {1'b0, start}) begin
        off = jv - {1'b0, start};
      end else begin
        off = jv + {1'b0, size} - {1'b0, start};
      end
      m[j] = (jv < {1'b0, size}) && (off < count);
    end
    return m;
  endfunction

endpackage

[src/swpb_front.sv]
// ----------------------------------------------------------------------------
// swpb_front
// Accepts input transactions, decodes the function code and queues them
// in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swpb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swpb_pkg::FUNC_W-1:0]   in_func,
  input  logic [swpb_pkg::SEQ_W-1:0]    in_seq,
  input  logic [swpb_pkg::PAY_W-1:0]    in_payload,
  output logic                          q_valid,
  output swpb_pkg::item_t               q_item,
  input  logic                          q_pop
);

  swpb_pkg::item_t fifo_r [2];
  logic [1:0]      cnt_r;
  logic            rd_ptr_r;
  logic            wr_ptr_r;
  swpb_pkg::item_t new_item;
  logic            push;

  always_comb begin
    new_item.seq     = in_seq;
    new_item.payload = in_payload;
    case (swpb_pkg::op_t'(in_func))
      swpb_pkg::OP_ADD, swpb_pkg::OP_READ, swpb_pkg::OP_REMOVE,
      swpb_pkg::OP_SLIDE, swpb_pkg::OP_SET: begin
        new_item.op = swpb_pkg::op_t'(in_func);
      end
      default: begin
        // unused codes behave as a query
        new_item.op = swpb_pkg::OP_QUERY;
      end
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
  end

  `SWPB_ASSERT(a_pop_nonempty, clk, rst_n, q_pop |-> q_valid, "pop from empty queue")
  `SWPB_ASSERT(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "queue count out of range")

endmodule

[src/swpb_mod.sv]
// ----------------------------------------------------------------------------
// swpb_mod
// Iterative remainder unit: 32-bit dividend modulo a 5-bit divisor,
// four dividend bits per cycle, with done flagging the result.
// ----------------------------------------------------------------------------
module swpb_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [swpb_pkg::SEQ_W-1:0]   dividend,
  input  logic [swpb_pkg::REM_W-1:0]   divisor,
  output logic                         done,
  output logic [swpb_pkg::REM_W-1:0]   rem
);

  logic [swpb_pkg::SEQ_W-1:0] dvd_r;
  logic [swpb_pkg::REM_W-1:0] div_r;
  logic [swpb_pkg::REM_W-1:0] rem_r;
  logic [swpb_pkg::REM_W-1:0] rem_nxt;
  logic [2:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;

  always_comb begin
    logic [swpb_pkg::REM_W:0] r;
    r = {1'b0, rem_r};
    for (int k = 0; k < 4; k++) begin
      r = {r[swpb_pkg::REM_W-1:0], dvd_r[swpb_pkg::SEQ_W-1-k]};
      if (r >= {1'b0, div_r}) begin
        r = r - {1'b0, div_r};
      end
    end
    rem_nxt = r[swpb_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[swpb_pkg::SEQ_W-5:0], 4'd0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[src/swpb_back.sv]
// ----------------------------------------------------------------------------
// swpb_back
// Executes queued operations: slot index by remainder units, packet store,
// valid bits, window edges, and the registered result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swpb_back #(
  parameter int STORE_DEPTH = swpb_pkg::DEF_STORE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [swpb_pkg::WS_W-1:0]   cfg_wr_data,
  input  logic                        q_valid,
  input  swpb_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swpb_pkg::PAY_W-1:0]  out_payload_out,
  output logic                        out_entry_valid,
  output logic                        out_in_window,
  output logic                        out_window_closed,
  output logic                        out_all_slots_valid,
  output logic                        out_all_slots_empty
);

  localparam int NSLOT  = (STORE_DEPTH < swpb_pkg::MAX_WIN) ? STORE_DEPTH : swpb_pkg::MAX_WIN;
  localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam logic [swpb_pkg::WS_W-1:0] SIZE_MAX = swpb_pkg::WS_W'(NSLOT);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_EXEC, ST_SCAN} state_t;

  state_t                       state_r;
  swpb_pkg::item_t              item_r;
  logic [swpb_pkg::WS_W-1:0]    ws_r;
  logic [swpb_pkg::SEQ_W-1:0]   bottom_r;
  logic [swpb_pkg::SEQ_W-1:0]   top_r;
  logic [swpb_pkg::SEQ_W-1:0]   nts_r;
  logic [NSLOT-1:0]             valid_r;
  logic [swpb_pkg::REM_W-1:0]   idx_r;
  logic [swpb_pkg::REM_W-1:0]   bidx_r;
  logic [swpb_pkg::REM_W-1:0]   b0_r;
  logic                         was_valid_r;
  logic [swpb_pkg::PAY_W-1:0]   rd_word_r;
  logic [swpb_pkg::PAY_W-1:0]   store [NSLOT];

  logic                         out_valid_r;
  logic [swpb_pkg::PAY_W-1:0]   out_payload_r;
  logic                         out_entry_valid_r;
  logic                         out_in_window_r;
  logic                         out_closed_r;
  logic                         out_all_v_r;
  logic                         out_all_e_r;

  logic                         mod_start;
  logic                         seq_done;
  logic                         bot_done;
  logic [swpb_pkg::REM_W-1:0]   seq_rem;
  logic [swpb_pkg::REM_W-1:0]   bot_rem;
  logic [swpb_pkg::REM_W-1:0]   size;
  logic [swpb_pkg::REM_W-1:0]   cfg_size;
  logic [SLOT_W-1:0]            slot;
  logic                         res_load;

  function automatic logic [swpb_pkg::REM_W-1:0] eff_size(input logic [swpb_pkg::WS_W-1:0] ws);
    logic [swpb_pkg::REM_W-1:0] s;
    if (ws == '0) begin
      s = swpb_pkg::REM_W'(1);
    end else if (ws > SIZE_MAX) begin
      s = SIZE_MAX;
    end else begin
      s = ws;
    end
    return s;
  endfunction

  assign size      = eff_size(ws_r);
  assign cfg_size  = eff_size(cfg_wr_data);
  assign slot      = idx_r[SLOT_W-1:0];
  assign mod_start = (state_r == ST_IDLE) && q_valid;
  assign q_pop     = mod_start;
  assign res_load  = (state_r == ST_SCAN) && (!out_valid_r || out_ready);

  swpb_mod u_mod_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (q_item.seq - swpb_pkg::SEQ_W'(1)),
    .divisor  (size),
    .done     (seq_done),
    .rem      (seq_rem)
  );

  swpb_mod u_mod_bot (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (bottom_r - swpb_pkg::SEQ_W'(1)),
    .divisor  (size),
    .done     (bot_done),
    .rem      (bot_rem)
  );

  // slide clearing run and post-operation scan
  logic [swpb_pkg::SEQ_W-1:0]   slide_gap;
  logic [swpb_pkg::CNT_W-1:0]   slide_n;
  logic [swpb_pkg::MAX_WIN-1:0] clr_run;
  logic [NSLOT-1:0]             clr_mask;
  logic [swpb_pkg::SEQ_W-1:0]   span;
  logic [swpb_pkg::CNT_W-1:0]   scan_n;
  logic [swpb_pkg::MAX_WIN-1:0] scan_run;
  logic [NSLOT-1:0]             scan_mask;
  logic                         scan_all_v;
  logic                         scan_all_e;

  always_comb begin
    slide_gap = item_r.seq - bottom_r;
    if (item_r.seq <= bottom_r) begin
      slide_n = '0;
    end else if (slide_gap > swpb_pkg::SEQ_W'(size)) begin
      slide_n = swpb_pkg::CNT_W'(size);
    end else begin
      slide_n = slide_gap[swpb_pkg::CNT_W-1:0];
    end
    clr_run  = swpb_pkg::slot_mask(bidx_r, slide_n, size);
    clr_mask = clr_run[NSLOT-1:0];

    span = top_r - bottom_r;
    if (span >= swpb_pkg::SEQ_W'(size)) begin
      scan_n = swpb_pkg::CNT_W'(size);
    end else begin
      scan_n = span[swpb_pkg::CNT_W-1:0] + swpb_pkg::CNT_W'(1);
    end
    scan_run  = swpb_pkg::slot_mask(b0_r, scan_n, size);
    scan_mask = scan_run[NSLOT-1:0];
    if (top_r < bottom_r) begin
      scan_all_v = 1'b1;
      scan_all_e = 1'b1;
    end else begin
      scan_all_v = &(valid_r | ~scan_mask);
      scan_all_e = ~|(valid_r & scan_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= swpb_pkg::WS_RESET;
      bottom_r    <= swpb_pkg::SEQ_W'(1);
      top_r       <= swpb_pkg::SEQ_W'(eff_size(swpb_pkg::WS_RESET));
      nts_r       <= swpb_pkg::SEQ_W'(1);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        ws_r  <= cfg_wr_data;
        top_r <= bottom_r + swpb_pkg::SEQ_W'(cfg_size) - swpb_pkg::SEQ_W'(1);
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (seq_done) begin
            idx_r   <= seq_rem;
            bidx_r  <= bot_rem;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          was_valid_r <= valid_r[slot];
          b0_r        <= bidx_r;
          case (item_r.op)
            swpb_pkg::OP_ADD: begin
              valid_r[slot] <= 1'b1;
            end
            swpb_pkg::OP_REMOVE: begin
              valid_r[slot] <= 1'b0;
            end
            swpb_pkg::OP_SLIDE: begin
              valid_r  <= valid_r & ~clr_mask;
              bottom_r <= item_r.seq;
              top_r    <= item_r.seq + swpb_pkg::SEQ_W'(size) - swpb_pkg::SEQ_W'(1);
              b0_r     <= idx_r;
              if (nts_r < item_r.seq) begin
                nts_r <= item_r.seq;
              end
            end
            swpb_pkg::OP_SET: begin
              nts_r <= item_r.seq;
            end
            default: begin
            end
          endcase
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          // hold until the result register is free
          if (res_load) begin
            out_payload_r     <= (item_r.op == swpb_pkg::OP_READ ||
                                  item_r.op == swpb_pkg::OP_REMOVE) ? rd_word_r : '0;
            out_entry_valid_r <= was_valid_r;
            out_in_window_r   <= (item_r.seq >= bottom_r) && (item_r.seq <= top_r);
            out_closed_r      <= nts_r > top_r;
            out_all_v_r       <= scan_all_v;
            out_all_e_r       <= scan_all_e;
            state_r           <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      rd_word_r <= store[slot];
      if (item_r.op == swpb_pkg::OP_ADD) begin
        store[slot] <= item_r.payload;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_out     = out_payload_r;
  assign out_entry_valid     = out_entry_valid_r;
  assign out_in_window       = out_in_window_r;
  assign out_window_closed   = out_closed_r;
  assign out_all_slots_valid = out_all_v_r;
  assign out_all_slots_empty = out_all_e_r;

  `SWPB_ASSERT(a_mod_lockstep, clk, rst_n, seq_done == bot_done, "remainder units out of step")
  `SWPB_ASSERT(a_div_to_exec, clk, rst_n, (state_r == ST_DIV && seq_done) |=> state_r == ST_EXEC, "missed remainder result")
  `SWPB_ASSERT(a_pop_idle, clk, rst_n, q_pop |-> state_r == ST_IDLE, "pop while busy")

endmodule

[src/sliding_window_packet_buffer.sv]
// ----------------------------------------------------------------------------
// sliding_window_packet_buffer
// Selective-repeat window store: add, read, remove, slide, set next-to-send
// and query operations, one status result per transaction.
//
//  channel | ports                                   | handshake
//  in      | in_func, in_seq, in_payload             | in_valid / in_ready
//  out     | out_payload_out, out_entry_valid, ...   | out_valid / out_ready
//  cfg     | cfg_wr_data (window size)               | cfg_wr_en, no wait
//
// A transaction passes the back-end states in order: dispatch, waiting on
// the remainder units (8 steps of 4 sequence bits, then the done flag),
// execute, and a scan that loads the result register.
// The front queue holds two transactions while the back end is busy.
// Reset is synchronous, active low; valid bits clear at once.
// A stalled result register holds the back end in its scan step.
// ----------------------------------------------------------------------------
module sliding_window_packet_buffer #(
  parameter int STORE_DEPTH = swpb_pkg::DEF_STORE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [swpb_pkg::WS_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swpb_pkg::FUNC_W-1:0] in_func,
  input  logic [swpb_pkg::SEQ_W-1:0]  in_seq,
  input  logic [swpb_pkg::PAY_W-1:0]  in_payload,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swpb_pkg::PAY_W-1:0]  out_payload_out,
  output logic                        out_entry_valid,
  output logic                        out_in_window,
  output logic                        out_window_closed,
  output logic                        out_all_slots_valid,
  output logic                        out_all_slots_empty
);

  logic            q_valid;
  logic            q_pop;
  swpb_pkg::item_t q_item;

  swpb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_seq     (in_seq),
    .in_payload (in_payload),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  swpb_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_out     (out_payload_out),
    .out_entry_valid     (out_entry_valid),
    .out_in_window       (out_in_window),
    .out_window_closed   (out_window_closed),
    .out_all_slots_valid (out_all_slots_valid),
    .out_all_slots_empty (out_all_slots_empty)
  );

endmodule
